FILE: rtl/psp_pkg.sv
package psp_pkg;

	// Fixed field widths of the command and result transactions
	localparam int unsigned CMD_W  = 2;
	localparam int unsigned LIFE_W = 24;
	localparam int unsigned DT_W   = 16;
	localparam int unsigned SLOT_W = 10;
	localparam int unsigned CNT_W  = 11;
	localparam int unsigned CFG_W  = 11;

	localparam logic [LIFE_W-1:0] AGE_MAX = {LIFE_W{1'b1}};
	localparam logic [CFG_W-1:0]  POOL_SIZE_RST = 11'd1024;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_SPAWN = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	// One queued command
	typedef struct packed {
		cmd_t              cmd;
		logic [LIFE_W-1:0] life;
		logic [DT_W-1:0]   dt;
	} item_t;

	// Handshake between front end and execution unit
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_req_t;

endpackage

FILE: rtl/psp_front.sv
module psp_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  logic [psp_pkg::CMD_W-1:0]   command,
	input  logic [psp_pkg::LIFE_W-1:0]  lifespan_ms,
	input  logic [psp_pkg::DT_W-1:0]    elapsed_ms,
	output psp_pkg::q_req_t             q_req,
	input  logic                        q_ready
);
	import psp_pkg::*;

	item_t      fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	item_t      in_item;

	// Classify the incoming transaction
	always_comb begin
		in_item.cmd  = cmd_t'(command);
		in_item.life = lifespan_ms;
		in_item.dt   = elapsed_ms;
	end

	assign cmd_ready   = (cnt_q != 2'd2);
	assign push        = cmd_valid && cmd_ready;
	assign q_req.valid = (cnt_q != 2'd0);
	assign q_req.item  = fifo_q[rd_ptr_q];
	assign pop         = q_req.valid && q_ready;

	// Two-entry command queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

FILE: rtl/psp_exec.sv
module psp_exec #(
	parameter int unsigned POOL_DEPTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [psp_pkg::CFG_W-1:0]   cfg_data,
	input  psp_pkg::q_req_t             q_req,
	output logic                        q_ready,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [psp_pkg::SLOT_W-1:0]  slot,
	output logic                        granted,
	output logic [psp_pkg::CNT_W-1:0]   live_count,
	output logic [psp_pkg::CNT_W-1:0]   expired_count
);
	import psp_pkg::*;

	localparam int unsigned IW = $clog2(POOL_DEPTH);
	localparam int unsigned PW = $clog2(POOL_DEPTH + 1);
	localparam int unsigned CW = (PW > CFG_W) ? PW : CFG_W;
	localparam int unsigned N_RST = (POOL_DEPTH < 1024) ? POOL_DEPTH : 1024;
	localparam logic [PW-1:0] NIL = PW'(POOL_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SPAWN_EX,
		S_TICK_EX,
		S_TICK_END
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  pool_size_q;
	logic [PW-1:0]     n_q;         // slots chained at last clear
	logic [PW-1:0]     bump_q;      // slots at and above here are untouched since clear
	logic [PW-1:0]     free_head_q;
	logic [PW-1:0]     active_head_q;
	logic [PW-1:0]     count_q;
	logic [PW-1:0]     p_q;
	logic [PW-1:0]     tail_q;
	logic [PW-1:0]     new_head_q;
	logic [PW-1:0]     kept_q;
	logic [PW-1:0]     exp_q;
	item_t             item_q;
	logic              res_valid_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_granted_q;
	logic [CNT_W-1:0]  res_live_q;
	logic [CNT_W-1:0]  res_exp_q;

	// Slot stores
	logic [PW-1:0]     link_mem [POOL_DEPTH];
	logic [LIFE_W-1:0] age_mem  [POOL_DEPTH];
	logic [LIFE_W-1:0] life_mem [POOL_DEPTH];
	logic [PW-1:0]     link_rd;
	logic [LIFE_W-1:0] age_rd;
	logic [LIFE_W-1:0] life_rd;

	logic              pop;
	logic              fh_implicit;
	logic [PW-1:0]     imp_next;
	logic [PW-1:0]     n_clr;
	logic [LIFE_W:0]   age_sum;
	logic [LIFE_W-1:0] age_new;
	logic              expire;
	logic [PW-1:0]     rd_addr;
	logic              link_we;
	logic [PW-1:0]     link_wa;
	logic [PW-1:0]     link_wd;
	logic              age_we;
	logic              life_we;
	logic [PW-1:0]     mem_wa;
	logic [LIFE_W-1:0] age_wd;
	logic [LIFE_W-1:0] life_wd;

	assign q_ready = (state_q == S_IDLE) && (!res_valid_q || res_ready);
	assign pop     = q_ready && q_req.valid;

	// Untouched free slots chain implicitly in index order
	assign fh_implicit = (free_head_q >= bump_q);
	assign imp_next    = ((free_head_q + PW'(1)) < n_q) ? (free_head_q + PW'(1)) : NIL;

	// Pool size clamped to the physical depth
	assign n_clr = (CW'(pool_size_q) > CW'(POOL_DEPTH)) ? NIL : PW'(pool_size_q);

	// Age update with saturation, expiry test
	assign age_sum = {1'b0, age_rd} + (LIFE_W + 1)'(item_q.dt);
	assign age_new = age_sum[LIFE_W] ? AGE_MAX : age_sum[LIFE_W-1:0];
	assign expire  = (age_new > life_rd);

	// Memory read address and write controls
	always_comb begin
		rd_addr = p_q;
		link_we = 1'b0;
		link_wa = p_q;
		link_wd = NIL;
		age_we  = 1'b0;
		life_we = 1'b0;
		mem_wa  = p_q;
		age_wd  = '0;
		life_wd = item_q.life;
		unique case (state_q)
			S_IDLE: begin
				rd_addr = (q_req.item.cmd == CMD_TICK) ? active_head_q : free_head_q;
				if (pop && q_req.item.cmd == CMD_SPAWN && free_head_q != NIL && fh_implicit) begin
					link_we = 1'b1;
					link_wa = free_head_q;
					link_wd = active_head_q;
					age_we  = 1'b1;
					life_we = 1'b1;
					mem_wa  = free_head_q;
					life_wd = q_req.item.life;
				end
			end
			S_SPAWN_EX: begin
				link_we = 1'b1;
				link_wd = active_head_q;
				age_we  = 1'b1;
				life_we = 1'b1;
			end
			S_TICK_EX: begin
				rd_addr = link_rd;
				age_we  = 1'b1;
				age_wd  = age_new;
				if (expire) begin
					link_we = 1'b1;
					link_wd = free_head_q;
				end else if (tail_q != NIL) begin
					link_we = 1'b1;
					link_wa = tail_q;
					link_wd = p_q;
				end
			end
			S_TICK_END: begin
				link_we = (tail_q != NIL);
				link_wa = tail_q;
				link_wd = NIL;
			end
			default: begin
				rd_addr = p_q;
			end
		endcase
	end

	// Stores with registered read
	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa[IW-1:0]] <= link_wd;
		end
		if (age_we) begin
			age_mem[mem_wa[IW-1:0]] <= age_wd;
		end
		if (life_we) begin
			life_mem[mem_wa[IW-1:0]] <= life_wd;
		end
		link_rd <= link_mem[rd_addr[IW-1:0]];
		age_rd  <= age_mem[rd_addr[IW-1:0]];
		life_rd <= life_mem[rd_addr[IW-1:0]];
	end

	// Sequencer, list heads and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pool_size_q   <= POOL_SIZE_RST;
			n_q           <= PW'(N_RST);
			bump_q        <= '0;
			free_head_q   <= '0;
			active_head_q <= NIL;
			count_q       <= '0;
			p_q           <= '0;
			tail_q        <= NIL;
			new_head_q    <= NIL;
			kept_q        <= '0;
			exp_q         <= '0;
			item_q        <= '0;
			res_valid_q   <= 1'b0;
			res_slot_q    <= '0;
			res_granted_q <= 1'b0;
			res_live_q    <= '0;
			res_exp_q     <= '0;
		end else begin
			if (cfg_we) begin
				pool_size_q <= cfg_data;
			end
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						item_q        <= q_req.item;
						res_slot_q    <= '0;
						res_granted_q <= 1'b0;
						res_exp_q     <= '0;
						res_live_q    <= CNT_W'(count_q);
						case (q_req.item.cmd)
							CMD_CLEAR: begin
								n_q           <= n_clr;
								bump_q        <= '0;
								free_head_q   <= (n_clr != '0) ? '0 : NIL;
								active_head_q <= NIL;
								count_q       <= '0;
								res_live_q    <= '0;
								res_valid_q   <= 1'b1;
							end
							CMD_SPAWN: begin
								p_q <= free_head_q;
								if (free_head_q == NIL) begin
									res_valid_q <= 1'b1;
								end else if (fh_implicit) begin
									free_head_q   <= imp_next;
									bump_q        <= free_head_q + PW'(1);
									active_head_q <= free_head_q;
									count_q       <= count_q + PW'(1);
									res_slot_q    <= SLOT_W'(free_head_q);
									res_granted_q <= 1'b1;
									res_live_q    <= CNT_W'(count_q + PW'(1));
									res_valid_q   <= 1'b1;
								end else begin
									state_q <= S_SPAWN_EX;
								end
							end
							CMD_TICK: begin
								p_q        <= active_head_q;
								tail_q     <= NIL;
								new_head_q <= NIL;
								kept_q     <= '0;
								exp_q      <= '0;
								if (active_head_q == NIL) begin
									res_valid_q <= 1'b1;
								end else begin
									state_q <= S_TICK_EX;
								end
							end
							default: begin
								res_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_SPAWN_EX: begin
					free_head_q   <= link_rd;
					active_head_q <= p_q;
					count_q       <= count_q + PW'(1);
					res_slot_q    <= SLOT_W'(p_q);
					res_granted_q <= 1'b1;
					res_live_q    <= CNT_W'(count_q + PW'(1));
					res_valid_q   <= 1'b1;
					state_q       <= S_IDLE;
				end
				S_TICK_EX: begin
					if (expire) begin
						free_head_q <= p_q;
						exp_q       <= exp_q + PW'(1);
					end else begin
						if (tail_q == NIL) begin
							new_head_q <= p_q;
						end
						tail_q <= p_q;
						kept_q <= kept_q + PW'(1);
					end
					p_q <= link_rd;
					if (link_rd == NIL) begin
						state_q <= S_TICK_END;
					end
				end
				S_TICK_END: begin
					active_head_q <= new_head_q;
					count_q       <= kept_q;
					res_live_q    <= CNT_W'(kept_q);
					res_exp_q     <= CNT_W'(exp_q);
					res_valid_q   <= 1'b1;
					state_q       <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid     = res_valid_q;
	assign slot          = res_slot_q;
	assign granted       = res_granted_q;
	assign live_count    = res_live_q;
	assign expired_count = res_exp_q;

	// Free head always lies inside the chained range
	a_free_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q != NIL |-> free_head_q < n_q)
		else $error("free head outside pool");

	// Untouched region never runs past the chained range
	a_bump_range: assert property (@(posedge clk) disable iff (!arst_n)
		bump_q <= n_q)
		else $error("bump pointer beyond pool size");

	// Live slots never outnumber the pool
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= n_q)
		else $error("live count beyond pool size");

	// A granted spawn leaves at least one live slot while the result waits
	a_grant_live: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_granted_q |-> count_q != '0)
		else $error("grant reported with empty active list");

	// Empty active list and zero count go together when idle
	a_head_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> ((active_head_q == NIL) == (count_q == '0)))
		else $error("active head and live count disagree");

endmodule

FILE: rtl/particle_slot_pool.sv
// Particle slot pool: slots sit on a free list and an active list sharing one
// link store. Commands are 0 clear, 1 spawn, 2 tick, 3 no operation; each
// command gives exactly one result transaction. A two-entry queue decouples
// command intake from execution. Clear and a spawn from never-used slots
// answer from idle; a spawn reusing a freed slot passes S_SPAWN_EX (link read).
// A tick runs S_TICK_EX then S_TICK_END, and answers from idle when none are
// live: the walk visits one slot per cycle through the registered link, age
// and lifetime stores. No clearing pass is needed after reset or clear.
// pool_size is written via cfg_we and takes effect at the next clear.
module particle_slot_pool #(
	parameter int unsigned POOL_DEPTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [psp_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  logic [psp_pkg::CMD_W-1:0]   command,
	input  logic [psp_pkg::LIFE_W-1:0]  lifespan_ms,
	input  logic [psp_pkg::DT_W-1:0]    elapsed_ms,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [psp_pkg::SLOT_W-1:0]  slot,
	output logic                        granted,
	output logic [psp_pkg::CNT_W-1:0]   live_count,
	output logic [psp_pkg::CNT_W-1:0]   expired_count
);
	import psp_pkg::*;

	q_req_t q_req;
	logic   q_ready;

	psp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.command     (command),
		.lifespan_ms (lifespan_ms),
		.elapsed_ms  (elapsed_ms),
		.q_req       (q_req),
		.q_ready     (q_ready)
	);

	psp_exec #(
		.POOL_DEPTH (POOL_DEPTH)
	) u_exec (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.q_req         (q_req),
		.q_ready       (q_ready),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.slot          (slot),
		.granted       (granted),
		.live_count    (live_count),
		.expired_count (expired_count)
	);

endmodule

FILE: bench/particle_slot_pool_tb.sv
`timescale 1ns / 100ps

module particle_slot_pool_tb;
	import psp_pkg::*;

	localparam int DEPTH      = 1024;
	localparam int NIL        = DEPTH;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              granted;
		logic [CNT_W-1:0]  live;
		logic [CNT_W-1:0]  expired;
	} pool_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               cmd_valid = 1'b0;
	logic               cmd_ready;
	logic [CMD_W-1:0]   command = CMD_NOP;
	logic [LIFE_W-1:0]  lifespan_ms = '0;
	logic [DT_W-1:0]    elapsed_ms = '0;
	logic               res_valid;
	logic               res_ready = 1'b0;
	logic [SLOT_W-1:0]  slot;
	logic               granted;
	logic [CNT_W-1:0]   live_count;
	logic [CNT_W-1:0]   expired_count;

	particle_slot_pool #(.POOL_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.command(command), .lifespan_ms(lifespan_ms), .elapsed_ms(elapsed_ms),
		.res_valid(res_valid), .res_ready(res_ready),
		.slot(slot), .granted(granted),
		.live_count(live_count), .expired_count(expired_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the pool
	int           size_reg;
	int           next_of [DEPTH];
	int           age_of [DEPTH];
	int           life_of [DEPTH];
	int           free_head;
	int           active_head;
	int           active_cnt;
	pool_result_t pending_results[$];

	int  mismatches = 0;
	int  idle_cycles = 0;
	bit  send_burst = 0;
	bit  recv_burst = 0;

	function automatic void relink_pool();
		int n;
		n = (size_reg > DEPTH) ? DEPTH : size_reg;
		for (int i = 0; i < DEPTH; i++)
			next_of[i] = (i + 1 < n) ? i + 1 : NIL;
		free_head = (n > 0) ? 0 : NIL;
		active_head = NIL;
		active_cnt = 0;
	endfunction

	// Work out the result of one accepted command and queue it
	function automatic void apply_command(cmd_t c, int life, int dt);
		pool_result_t r;
		int p, nx, a, new_head, tail, kept, steps, exp_n, s;
		r = '0;
		exp_n = 0;
		case (c)
			CMD_CLEAR: relink_pool();
			CMD_SPAWN: begin
				if (free_head < DEPTH) begin
					s = free_head;
					free_head = next_of[s];
					next_of[s] = active_head;
					active_head = s;
					life_of[s] = life;
					age_of[s] = 0;
					active_cnt++;
					r.slot = s[SLOT_W-1:0];
					r.granted = 1'b1;
				end
			end
			CMD_TICK: begin
				p = active_head;
				new_head = NIL;
				tail = NIL;
				kept = 0;
				steps = 0;
				while (p < DEPTH && steps < DEPTH) begin
					nx = next_of[p];
					a = age_of[p] + dt;
					if (a > int'(AGE_MAX))
						a = int'(AGE_MAX);
					age_of[p] = a;
					if (a > life_of[p]) begin
						next_of[p] = free_head;
						free_head = p;
						exp_n++;
					end else begin
						next_of[p] = NIL;
						if (tail == NIL)
							new_head = p;
						else
							next_of[tail] = p;
						tail = p;
						kept++;
					end
					p = nx;
					steps++;
				end
				active_head = new_head;
				active_cnt = kept;
			end
			default: ;
		endcase
		r.live = active_cnt[CNT_W-1:0];
		r.expired = exp_n[CNT_W-1:0];
		pending_results.push_back(r);
	endfunction

	// Offer one command transaction and wait for it to be taken
	task automatic send_cmd(cmd_t c, logic [LIFE_W-1:0] life, logic [DT_W-1:0] dt);
		int  gap;
		bit  rdy;
		gap = send_burst ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command <= c;
		lifespan_ms <= life;
		elapsed_ms <= dt;
		do begin
			@(negedge clk);
			rdy = cmd_ready;
			@(posedge clk);
		end while (!rdy);
		apply_command(c, int'(life), int'(dt));
	endtask

	// Let the block drain, then write pool_size
	task automatic set_pool_size(int value);
		cmd_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		size_reg = value & 16'h7FF;
	endtask

	// Result checker
	initial begin : result_checker
		int           stall;
		bit           vld;
		pool_result_t got, want;
		int           n_seen;
		n_seen = 0;
		@(posedge arst_n);
		forever begin
			if (n_seen % 64 == 0)
				recv_burst = ($urandom_range(0, 3) == 0);
			stall = recv_burst ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			do begin
				@(negedge clk);
				vld = res_valid;
				got = '{slot, granted, live_count, expired_count};
				@(posedge clk);
			end while (!vld);
			n_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: slot %0d/%0d granted %0b/%0b live %0d/%0d expired %0d/%0d (exp/act)",
							want.slot, got.slot, want.granted, got.granted,
							want.live, got.live, want.expired, got.expired);
				end
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Reset chain: slots handed out in index order
	task automatic test_reset_chain();
		send_cmd(CMD_SPAWN, 24'd10, 16'hFFFF);
		send_cmd(CMD_SPAWN, 24'hFFFFFF, 16'h0000);
		send_cmd(CMD_TICK, 24'hFFFFFF, 16'd11);
		send_cmd(CMD_SPAWN, 24'd0, 16'd0);
		send_cmd(CMD_NOP, 24'hABCDEF, 16'h1234);
	endtask

	// Small pool runs dry, spawn on empty pool fails
	task automatic test_exhaustion();
		set_pool_size(2);
		send_cmd(CMD_CLEAR, 24'd0, 16'd0);
		send_cmd(CMD_SPAWN, 24'd5, 16'd0);
		send_cmd(CMD_SPAWN, 24'd0, 16'd0);
		send_cmd(CMD_SPAWN, 24'd7, 16'd0);
		// exact boundary: age equal to lifetime survives
		send_cmd(CMD_TICK, 24'd0, 16'd0);
		send_cmd(CMD_TICK, 24'd0, 16'd5);
		send_cmd(CMD_TICK, 24'd0, 16'd1);
		send_cmd(CMD_SPAWN, 24'd3, 16'd0);
		send_cmd(CMD_NOP, 24'd0, 16'd0);
	endtask

	// Out-of-range and empty pool sizes
	task automatic test_size_extremes();
		set_pool_size(0);
		send_cmd(CMD_CLEAR, 24'd0, 16'd0);
		send_cmd(CMD_SPAWN, 24'd9, 16'd0);
		send_cmd(CMD_TICK, 24'd0, 16'd1);
		set_pool_size(1);
		send_cmd(CMD_CLEAR, 24'd0, 16'd0);
		send_cmd(CMD_SPAWN, 24'd9, 16'd0);
		send_cmd(CMD_SPAWN, 24'd9, 16'd0);
		set_pool_size(2047);
		send_cmd(CMD_CLEAR, 24'd0, 16'd0);
		send_cmd(CMD_SPAWN, 24'd9, 16'd0);
	endtask

	// Age saturates at the top and never passes a full lifetime
	task automatic test_age_saturation();
		set_pool_size(4);
		send_cmd(CMD_CLEAR, 24'd0, 16'd0);
		send_cmd(CMD_SPAWN, 24'hFFFFFF, 16'd0);
		send_cmd(CMD_SPAWN, 24'hFFFFFE, 16'd0);
		send_burst = 1;
		for (int i = 0; i < 260; i++)
			send_cmd(CMD_TICK, 24'($urandom), 16'hFFFF);
		send_burst = 0;
	endtask

	// Random command streams under one pool size
	task automatic test_random_stream(int size, int n_items);
		int            r;
		cmd_t          c;
		logic [23:0]   life;
		logic [15:0]   dt;
		set_pool_size(size);
		send_cmd(CMD_CLEAR, 24'($urandom), 16'($urandom));
		for (int i = 0; i < n_items; i++) begin
			if (i % 50 == 0)
				send_burst = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			c = (r < 3) ? CMD_CLEAR : (r < 7) ? CMD_NOP : (r < 60) ? CMD_SPAWN : CMD_TICK;
			r = $urandom_range(0, 99);
			life = (r < 60) ? 24'($urandom_range(0, 3000)) : (r < 85) ? 24'($urandom) :
				(r < 93) ? 24'hFFFFFF : 24'd0;
			r = $urandom_range(0, 99);
			dt = (r < 70) ? 16'($urandom_range(0, 400)) : (r < 90) ? 16'($urandom) :
				(r < 95) ? 16'hFFFF : 16'd0;
			send_cmd(c, life, dt);
		end
		send_burst = 0;
	endtask

	initial begin : stimulus
		size_reg = int'(POOL_SIZE_RST);
		for (int i = 0; i < DEPTH; i++) begin
			age_of[i] = 0;
			life_of[i] = 0;
		end
		relink_pool();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_chain();
		test_exhaustion();
		test_size_extremes();
		test_age_saturation();
		test_random_stream(2, 210);
		test_random_stream(16, 250);
		test_random_stream(1024, 250);
		test_random_stream($urandom_range(3, 200), 250);
		test_random_stream(1, 100);
		test_random_stream($urandom_range(2, 1024), 250);
		test_random_stream(37, 100);

		cmd_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
